// ===== src/bdi_compressed_line_size_top_assert.svh =====
// Assertion macros for the BDI line size checker.
`ifndef BDI_COMPRESSED_LINE_SIZE_TOP_ASSERT_SVH
`define BDI_COMPRESSED_LINE_SIZE_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BDIC_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bdic check failed");

// Check a property on every clock edge, reset included.
`define BDIC_CHECK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("bdic reset check failed");

`endif

// ===== src/bdic_pkg.sv =====
// Types, constants and range checks for the BDI line size pipeline.
package bdic_pkg;

  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned LINE_BITS = 512;
  localparam int unsigned N8 = 8;
  localparam int unsigned N4 = 16;
  localparam int unsigned N2 = 32;

  localparam logic [6:0] LINE_BYTES = 7'd64;
  localparam logic [6:0] SIZE_ZERO  = 7'd1;
  localparam logic [6:0] SIZE_REP4  = 7'd4;
  localparam logic [6:0] SIZE_REP8  = 7'd8;
  localparam logic [6:0] SIZE_B8D1  = 7'd16;
  localparam logic [6:0] SIZE_B4D1  = 7'd20;
  localparam logic [6:0] SIZE_B8D2  = 7'd24;
  localparam logic [6:0] SIZE_B2D1  = 7'd34;
  localparam logic [6:0] SIZE_B4D2  = 7'd36;
  localparam logic [6:0] SIZE_B8D4  = 7'd40;

  // Per-element fit flags: z* against the zero base, f* against element 0.
  typedef struct packed {
    logic            zero;
    logic            same8;
    logic            same4;
    logic [N8-1:0]   e8_z1;
    logic [N8-1:0]   e8_z2;
    logic [N8-1:0]   e8_z4;
    logic [N8-1:0]   e8_f1;
    logic [N8-1:0]   e8_f2;
    logic [N8-1:0]   e8_f4;
    logic [N4-1:0]   e4_z1;
    logic [N4-1:0]   e4_z2;
    logic [N4-1:0]   e4_f1;
    logic [N4-1:0]   e4_f2;
    logic [N2-1:0]   e2_z1;
    logic [N2-1:0]   e2_f1;
  } fit_flags_t;

  // Which encodings apply to the whole line.
  typedef struct packed {
    logic zero;
    logic rep4;
    logic rep8;
    logic b8d1;
    logic b4d1;
    logic b8d2;
    logic b2d1;
    logic b4d2;
    logic b8d4;
  } enc_flags_t;

  // Two's complement value lies within [-0xFF, 0xFF].
  function automatic logic fit_lim8(input logic [63:0] d);
    return (d[63:8] == '0) || ((&d[63:8]) && (|d[7:0]));
  endfunction

  // Two's complement value lies within [-0xFFFF, 0xFFFF].
  function automatic logic fit_lim16(input logic [63:0] d);
    return (d[63:16] == '0) || ((&d[63:16]) && (|d[15:0]));
  endfunction

  // Two's complement value lies within [-0xFFFFFFFF, 0xFFFFFFFF].
  function automatic logic fit_lim32(input logic [63:0] d);
    return (d[63:32] == '0) || ((&d[63:32]) && (|d[31:0]));
  endfunction

endpackage

// ===== src/bdic_fit.sv =====
// Element fit stage: differences and range checks for every element size.
module bdic_fit
  import bdic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 line_valid,
  input  logic [LINE_BITS-1:0] line,
  output logic                 flags_valid,
  output fit_flags_t           flags
);

  logic [N8-1:0] z81, z82, z84, f81, f82, f84, eq8;
  logic [N4-1:0] z41, z42, f41, f42, eq4;
  logic [N2-1:0] z21, f21;
  fit_flags_t    flags_next;

  genvar i;
  generate
    for (i = 0; i < N8; i++) begin : g_e8
      logic [63:0] v, d;
      assign v = line[i*64 +: 64];
      // Wrap the difference at 64 bits.
      assign d = line[63:0] - v;
      assign z81[i] = fit_lim8(v);
      assign z82[i] = fit_lim16(v);
      assign z84[i] = fit_lim32(v);
      assign f81[i] = fit_lim8(d);
      assign f82[i] = fit_lim16(d);
      assign f84[i] = fit_lim32(d);
      assign eq8[i] = (v == line[63:0]);
    end
    for (i = 0; i < N4; i++) begin : g_e4
      logic [31:0] v;
      logic [32:0] d;
      logic [63:0] dx;
      assign v  = line[i*32 +: 32];
      assign d  = {1'b0, line[31:0]} - {1'b0, v};
      assign dx = {{31{d[32]}}, d};
      assign z41[i] = fit_lim8({32'd0, v});
      assign z42[i] = fit_lim16({32'd0, v});
      assign f41[i] = fit_lim8(dx);
      assign f42[i] = fit_lim16(dx);
      assign eq4[i] = (v == line[31:0]);
    end
    for (i = 0; i < N2; i++) begin : g_e2
      logic [15:0] v;
      logic [16:0] d;
      logic [63:0] dx;
      assign v  = line[i*16 +: 16];
      assign d  = {1'b0, line[15:0]} - {1'b0, v};
      assign dx = {{47{d[16]}}, d};
      assign z21[i] = fit_lim8({48'd0, v});
      assign f21[i] = fit_lim8(dx);
    end
  endgenerate

  always_comb begin
    flags_next.zero  = (line == '0);
    flags_next.same8 = &eq8;
    flags_next.same4 = &eq4;
    flags_next.e8_z1 = z81;
    flags_next.e8_z2 = z82;
    flags_next.e8_z4 = z84;
    flags_next.e8_f1 = f81;
    flags_next.e8_f2 = f82;
    flags_next.e8_f4 = f84;
    flags_next.e4_z1 = z41;
    flags_next.e4_z2 = z42;
    flags_next.e4_f1 = f41;
    flags_next.e4_f2 = f42;
    flags_next.e2_z1 = z21;
    flags_next.e2_f1 = f21;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_valid <= 1'b0;
    end else begin
      flags_valid <= line_valid;
    end
    flags <= flags_next;
  end

endmodule

// ===== src/bdi_compressed_line_size_top.sv =====
// Top level: four-stage pipeline computing the BDI compressed size of a line.
// Path: an accepted line passes the line, fit flag, encoding and result
//   registers in order; done then goes high with its compressed size.
// Throughput: one line per cycle; busy stays low, there is no backpressure.
// Reset: synchronous rst clears every stage valid bit; payload is not reset.
// Rate is set by the element fit stage (64-bit subtract plus range check).
module bdi_compressed_line_size_top
  import bdic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] word0,
  input  logic [63:0] word1,
  input  logic [63:0] word2,
  input  logic [63:0] word3,
  input  logic [63:0] word4,
  input  logic [63:0] word5,
  input  logic [63:0] word6,
  input  logic [63:0] word7,
  output logic        done,
  output logic [6:0]  compressed_size
);

  // Stage 1: capture the line.
  logic                 line_valid;
  logic [LINE_BITS-1:0] line;

  // Stage 2: per-element fit flags.
  logic                 flags_valid;
  fit_flags_t           flags;

  // Stage 3: per-encoding verdicts.
  logic                 enc_valid;
  enc_flags_t           enc;
  enc_flags_t           enc_next;

  logic [6:0]           size_next;

  // Every cycle can take a new transaction.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else begin
      line_valid <= start;
    end
    line <= {word7, word6, word5, word4, word3, word2, word1, word0};
  end

  bdic_fit u_fit (
    .clk         (clk),
    .rst         (rst),
    .line_valid  (line_valid),
    .line        (line),
    .flags_valid (flags_valid),
    .flags       (flags)
  );

  // Reduce element flags. Element 0 joins as a second base only when it
  // does not fit against the zero base itself.
  always_comb begin
    enc_next.zero = flags.zero;
    enc_next.rep8 = flags.same8;
    enc_next.rep4 = flags.same4;
    enc_next.b8d1 = &(flags.e8_z1 | (flags.e8_f1 & {N8{~flags.e8_z1[0]}}));
    enc_next.b8d2 = &(flags.e8_z2 | (flags.e8_f2 & {N8{~flags.e8_z2[0]}}));
    enc_next.b8d4 = &(flags.e8_z4 | (flags.e8_f4 & {N8{~flags.e8_z4[0]}}));
    enc_next.b4d1 = &(flags.e4_z1 | (flags.e4_f1 & {N4{~flags.e4_z1[0]}}));
    enc_next.b4d2 = &(flags.e4_z2 | (flags.e4_f2 & {N4{~flags.e4_z2[0]}}));
    enc_next.b2d1 = &(flags.e2_z1 | (flags.e2_f1 & {N2{~flags.e2_z1[0]}}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid <= 1'b0;
    end else begin
      enc_valid <= flags_valid;
    end
    enc <= enc_next;
  end

  // Pick the smallest applicable size; arms are ordered by size.
  always_comb begin
    if (enc.zero) begin
      size_next = SIZE_ZERO;
    end else if (enc.rep4) begin
      size_next = SIZE_REP4;
    end else if (enc.rep8) begin
      size_next = SIZE_REP8;
    end else if (enc.b8d1) begin
      size_next = SIZE_B8D1;
    end else if (enc.b4d1) begin
      size_next = SIZE_B4D1;
    end else if (enc.b8d2) begin
      size_next = SIZE_B8D2;
    end else if (enc.b2d1) begin
      size_next = SIZE_B2D1;
    end else if (enc.b4d2) begin
      size_next = SIZE_B4D2;
    end else if (enc.b8d4) begin
      size_next = SIZE_B8D4;
    end else begin
      size_next = LINE_BYTES;
    end
  end

  // Stage 4: result register; done strobes for exactly one cycle per line.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= enc_valid;
    end
    compressed_size <= size_next;
  end

endmodule

// ===== src/bdic_checker.sv =====
// Port-level checker for the BDI line size block, bound to the top level.
`include "bdi_compressed_line_size_top_assert.svh"

module bdic_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [63:0] word0,
  input logic [63:0] word1,
  input logic [63:0] word2,
  input logic [63:0] word3,
  input logic [63:0] word4,
  input logic [63:0] word5,
  input logic [63:0] word6,
  input logic [63:0] word7,
  input logic        done,
  input logic [6:0]  compressed_size
);

  logic accept;
  logic zero_line;

  assign accept    = start && !busy;
  assign zero_line = (word0 == 64'd0) && (word1 == 64'd0) && (word2 == 64'd0) &&
                     (word3 == 64'd0) && (word4 == 64'd0) && (word5 == 64'd0) &&
                     (word6 == 64'd0) && (word7 == 64'd0);

  // Every transaction yields its result with done.
  `BDIC_CHECK(a_result_follows, accept |-> ##4 done)
  // No result appears without an earlier transaction.
  `BDIC_CHECK(a_no_spurious, done |-> $past(accept, 4))
  // An all-zero line compresses to one byte.
  `BDIC_CHECK(a_zero_line, (accept && zero_line) |-> ##4 (compressed_size == 7'd1))
  // Reset drops any result in flight.
  `BDIC_CHECK_ALWAYS(a_reset_clears, rst |=> !done)

endmodule

bind bdi_compressed_line_size_top bdic_checker u_bdic_checker (.*);
